[sv/trsf_pkg.sv]
package trsf_pkg;

	// Field widths fixed by the report format.
	localparam int unsigned ID_W     = 6;
	localparam int unsigned RAW_W    = 16;
	localparam int unsigned SCREEN_W = 13;
	localparam int unsigned COORD_W  = 12;
	localparam int unsigned SLOT_OUT_W = 4;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Product of a raw coordinate and (screen - 1), and the divider length.
	localparam int unsigned PROD_W    = RAW_W + SCREEN_W;
	localparam int unsigned DIV_STEPS = PROD_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	localparam logic [COORD_W-1:0] COORD_MAX = '1;

	localparam int unsigned DEF_SLOTS = 10;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT  = 2'd3;

	localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH  = 13'd800;
	localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
	localparam logic [RAW_W-1:0]    RST_PANEL_WIDTH   = 16'd0;
	localparam logic [RAW_W-1:0]    RST_PANEL_HEIGHT  = 16'd0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

[sv/touch_report_scale_filter.sv]
// Channel   | Handshake            | Payload
// ----------+----------------------+--------------------------------------------------
// input     | in_valid / in_ready  | kind, touch_id, touching, raw_x, raw_y
// result    | out_valid / out_ready| point_valid, frame_sync, slot, pressed,
//           |                      | screen_x, screen_y
// config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A point report with a valid id is accepted, then for each axis it passes through the
// multiply state and the shared one-bit-per-cycle restoring divider, and finally the
// emit state checks the slot table and loads the result register.
// An axis whose panel extent or screen size is zero skips its division.
// A frame-end marker goes straight to the emit state, and a report with a bad id
// is accepted but leaves no result.
// arst_n resets the sequencer, the result valid flag and the slot table (every slot
// released at position zero), and loads the configuration registers' reset values.
// A result waits in its output register while the next request is accepted; the
// sequencer only stalls in its final cycle if that register is still full.
module touch_report_scale_filter
	import trsf_pkg::*;
#(
	parameter int unsigned SLOTS = DEF_SLOTS
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   kind,
	input  logic [ID_W-1:0]        touch_id,
	input  logic                   touching,
	input  logic [RAW_W-1:0]       raw_x,
	input  logic [RAW_W-1:0]       raw_y,

	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   point_valid,
	output logic                   frame_sync,
	output logic [SLOT_OUT_W-1:0]  slot,
	output logic                   pressed,
	output logic [COORD_W-1:0]     screen_x,
	output logic [COORD_W-1:0]     screen_y,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Configuration registers.
	logic [SCREEN_W-1:0] screen_width_q;
	logic [SCREEN_W-1:0] screen_height_q;
	logic [RAW_W-1:0]    panel_width_q;
	logic [RAW_W-1:0]    panel_height_q;

	// Sequencer and the request held while it is worked on.
	state_t              state_q;
	state_t              state_d;
	logic                frame_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                touching_q;
	logic [RAW_W-1:0]    raw_x_q;
	logic [RAW_W-1:0]    raw_y_q;
	logic                axis_q;

	// Shared divider.
	logic [PROD_W-1:0]   dividend_q;
	logic [PROD_W-1:0]   quot_q;
	logic [RAW_W-1:0]    rem_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [COORD_W-1:0]  x_res_q;
	logic [COORD_W-1:0]  y_res_q;

	// Slot table: last status and scaled position of each contact.
	logic                tbl_st_q [SLOTS];
	logic [COORD_W-1:0]  tbl_x_q  [SLOTS];
	logic [COORD_W-1:0]  tbl_y_q  [SLOTS];

	// Result register.
	logic                out_valid_q;
	logic                point_valid_q;
	logic                frame_sync_q;
	logic [SLOT_OUT_W-1:0] slot_out_q;
	logic                pressed_q;
	logic [COORD_W-1:0]  screen_x_q;
	logic [COORD_W-1:0]  screen_y_q;

	logic                in_acc;
	logic                id_bad;
	logic                out_free;

	// Operands of the axis being scaled.
	logic [RAW_W-1:0]    op_raw;
	logic [SCREEN_W-1:0] op_screen;
	logic [RAW_W-1:0]    op_ext;
	logic [SCREEN_W-1:0] screen_m1;
	logic [COORD_W-1:0]  lim;
	logic                axis_zero;
	logic [PROD_W-1:0]   product;

	// One divider step.
	logic [RAW_W:0]      rem_sh;
	logic                ge;
	logic [RAW_W:0]      rem_sub;
	logic [PROD_W-1:0]   quot_n;
	logic [COORD_W-1:0]  q_sat;
	logic                div_last;

	// Slot table check.
	logic                drop;
	logic [5:0]          slot_wide;

	assign in_acc = in_valid && in_ready;
	assign id_bad = (touch_id == '0) || (32'(touch_id) > SLOTS);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		op_raw    = axis_q ? raw_y_q : raw_x_q;
		op_screen = axis_q ? screen_height_q : screen_width_q;
		op_ext    = axis_q ? panel_height_q : panel_width_q;
		screen_m1 = op_screen - SCREEN_W'(1);
		lim       = (screen_m1 > SCREEN_W'(COORD_MAX)) ? COORD_MAX : screen_m1[COORD_W-1:0];
		axis_zero = (op_screen == '0) || (op_ext == '0);
		product   = PROD_W'(op_raw) * PROD_W'(screen_m1);
	end

	// Restoring division: bring down one dividend bit and subtract if it fits.
	always_comb begin
		rem_sh   = {rem_q, dividend_q[PROD_W-1]};
		ge       = rem_sh >= {1'b0, op_ext};
		rem_sub  = rem_sh - {1'b0, op_ext};
		quot_n   = {quot_q[PROD_W-2:0], ge};
		q_sat    = (quot_n > PROD_W'(lim)) ? lim : quot_n[COORD_W-1:0];
		div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
	end

	// A repeated release, or a repeated touch at the same place, is dropped.
	always_comb begin
		drop = (touching_q == tbl_st_q[slot_q])
			&& (!touching_q || ((x_res_q == tbl_x_q[slot_q]) && (y_res_q == tbl_y_q[slot_q])));
		slot_wide = 6'(slot_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (kind) begin
						state_d = ST_EMIT;
					end else if (!id_bad) begin
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				if (!axis_zero) begin
					state_d = ST_DIV;
				end else if (axis_q) begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = axis_q ? ST_EMIT : ST_MUL;
				end
			end
			ST_EMIT: begin
				if (out_free || (!frame_q && drop)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Handshake outputs.
	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		cfg_ready   = 1'b1;
		out_valid   = out_valid_q;
		point_valid = point_valid_q;
		frame_sync  = frame_sync_q;
		slot        = slot_out_q;
		pressed     = pressed_q;
		screen_x    = screen_x_q;
		screen_y    = screen_y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= RST_SCREEN_WIDTH;
			screen_height_q <= RST_SCREEN_HEIGHT;
			panel_width_q   <= RST_PANEL_WIDTH;
			panel_height_q  <= RST_PANEL_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[SCREEN_W-1:0];
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data[SCREEN_W-1:0];
				CFG_PANEL_WIDTH:   panel_width_q   <= cfg_data[RAW_W-1:0];
				CFG_PANEL_HEIGHT:  panel_height_q  <= cfg_data[RAW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Request capture and the datapath of the shared divider.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					frame_q    <= kind;
					slot_q     <= SLOT_W'(touch_id - ID_W'(1));
					touching_q <= touching;
					raw_x_q    <= raw_x;
					raw_y_q    <= raw_y;
					axis_q     <= 1'b0;
				end
			end
			ST_MUL: begin
				dividend_q <= product;
				quot_q     <= '0;
				rem_q      <= '0;
				cnt_q      <= '0;
				if (axis_zero) begin
					if (axis_q) begin
						y_res_q <= '0;
					end else begin
						x_res_q <= '0;
						axis_q  <= 1'b1;
					end
				end
			end
			ST_DIV: begin
				dividend_q <= {dividend_q[PROD_W-2:0], 1'b0};
				quot_q     <= quot_n;
				rem_q      <= ge ? rem_sub[RAW_W-1:0] : rem_sh[RAW_W-1:0];
				cnt_q      <= cnt_q + CNT_W'(1);
				if (div_last) begin
					if (axis_q) begin
						y_res_q <= q_sat;
					end else begin
						x_res_q <= q_sat;
						axis_q  <= 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// The slot table is updated in the same cycle that loads a contact result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				tbl_st_q[i] <= 1'b0;
				tbl_x_q[i]  <= '0;
				tbl_y_q[i]  <= '0;
			end
		end else if ((state_q == ST_EMIT) && !frame_q && !drop && out_free) begin
			tbl_st_q[slot_q] <= touching_q;
			tbl_x_q[slot_q]  <= x_res_q;
			tbl_y_q[slot_q]  <= y_res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free && (frame_q || !drop)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; a release carries no position and a frame end carries nothing.
	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free && (frame_q || !drop)) begin
			point_valid_q <= !frame_q;
			frame_sync_q  <= frame_q;
			slot_out_q    <= frame_q ? '0 : slot_wide[SLOT_OUT_W-1:0];
			pressed_q     <= !frame_q && touching_q;
			screen_x_q    <= (!frame_q && touching_q) ? x_res_q : '0;
			screen_y_q    <= (!frame_q && touching_q) ? y_res_q : '0;
		end
	end

endmodule

[tb/touch_report_scale_filter_tb.sv]
module touch_report_scale_filter_tb;
	import trsf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The block is built with its default number of tracking slots, and the
	// local contact table below mirrors that size.
	localparam int TRACK_SLOTS = DEF_SLOTS;

	// A report either carries one contact or marks the end of a panel frame.
	localparam logic KIND_POINT     = 1'b0;
	localparam logic KIND_FRAME_END = 1'b1;

	// The settle wait lets a good-id point report that produces nothing
	// clear the datapath before the registers are touched again.
	localparam int SETTLE_CYCLES   = 80;
	localparam int QUIET_LIMIT     = 4000;
	localparam int RANDOM_PHASES   = 5;
	localparam int REPORTS_PER_PHASE = 205;
	localparam int IDLE_PERCENT    = 23;
	localparam int LONG_HOLD_CYCLES = 900;

	typedef struct packed {
		logic                  kind;
		logic [ID_W-1:0]       touch_id;
		logic                  touching;
		logic [RAW_W-1:0]      raw_x;
		logic [RAW_W-1:0]      raw_y;
	} touch_req_t;

	typedef struct packed {
		logic                  point_valid;
		logic                  frame_sync;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  pressed;
		logic [COORD_W-1:0]    screen_x;
		logic [COORD_W-1:0]    screen_y;
	} touch_evt_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  kind = KIND_POINT;
	logic [ID_W-1:0]       touch_id = '0;
	logic                  touching = 1'b0;
	logic [RAW_W-1:0]      raw_x = '0;
	logic [RAW_W-1:0]      raw_y = '0;

	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  point_valid;
	logic                  frame_sync;
	logic [SLOT_OUT_W-1:0] slot;
	logic                  pressed;
	logic [COORD_W-1:0]    screen_x;
	logic [COORD_W-1:0]    screen_y;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_SCREEN_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	touch_report_scale_filter u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.touch_id    (touch_id),
		.touching    (touching),
		.raw_x       (raw_x),
		.raw_y       (raw_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.point_valid (point_valid),
		.frame_sync  (frame_sync),
		.slot        (slot),
		.pressed     (pressed),
		.screen_x    (screen_x),
		.screen_y    (screen_y),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Local copy of the scaling registers, kept in step with every write that
	// the block accepts. They start at the block's reset values.
	logic [SCREEN_W-1:0]   scr_width  = RST_SCREEN_WIDTH;
	logic [SCREEN_W-1:0]   scr_height = RST_SCREEN_HEIGHT;
	logic [RAW_W-1:0]      pan_width  = RST_PANEL_WIDTH;
	logic [RAW_W-1:0]      pan_height = RST_PANEL_HEIGHT;

	// Local contact table: last status and last scaled position of each slot.
	// After reset every slot is released at position zero.
	logic                  contact_down [TRACK_SLOTS];
	logic [COORD_W-1:0]    contact_x    [TRACK_SLOTS];
	logic [COORD_W-1:0]    contact_y    [TRACK_SLOTS];

	// Last raw position handed out per touch id, so that the random part can
	// revisit a position and exercise the repeat filter.
	logic [RAW_W-1:0]      last_raw_x [64];
	logic [RAW_W-1:0]      last_raw_y [64];

	touch_req_t            pending_reports [$];
	touch_evt_t            expected_events [$];
	touch_req_t            cur_req;

	int                    queued_total    = 0;
	int                    accepted_total  = 0;
	int                    frame_total     = 0;
	int                    filtered_total  = 0;
	int                    results_checked = 0;
	int                    reg_writes      = 0;
	int                    mismatch_count  = 0;
	int                    quiet_cycles    = 0;
	int                    hold_left       = 0;
	bit                    long_hold_done  = 1'b0;

	initial begin
		for (int i = 0; i < TRACK_SLOTS; i++) begin
			contact_down[i] = 1'b0;
			contact_x[i]    = '0;
			contact_y[i]    = '0;
		end
		for (int i = 0; i < 64; i++) begin
			last_raw_x[i] = '0;
			last_raw_y[i] = '0;
		end
	end

	initial begin
		forever #5 clk = ~clk;
	end

	// Scales one raw coordinate to screen units: raw * (screen - 1) / extent,
	// truncated, then clamped to screen - 1 and to the 12-bit field. A zero
	// extent or a zero screen size gives zero.
	function automatic logic [COORD_W-1:0] scale_axis(input logic [RAW_W-1:0] raw,
			input logic [SCREEN_W-1:0] screen, input logic [RAW_W-1:0] extent);
		longint unsigned span;
		longint unsigned quot;
		if (extent == 0 || screen == 0) begin
			return '0;
		end
		span = longint'(screen) - 1;
		quot = (longint'(raw) * span) / longint'(extent);
		if (span > 4095) begin
			span = 4095;
		end
		if (quot > span) begin
			quot = span;
		end
		return quot[COORD_W-1:0];
	endfunction

	// Applies one report to the local contact table and works out the result
	// it should cause. Returns 0 when the block is meant to stay silent.
	function automatic bit track_report(input touch_req_t r, output touch_evt_t ev);
		int                 s;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		ev = '0;
		if (r.kind == KIND_FRAME_END) begin
			ev.frame_sync = 1'b1;
			return 1'b1;
		end
		if (r.touch_id == 0 || r.touch_id > TRACK_SLOTS) begin
			return 1'b0;
		end
		s = r.touch_id - 1;
		x = scale_axis(r.raw_x, scr_width, pan_width);
		y = scale_axis(r.raw_y, scr_height, pan_height);
		// A repeated release is dropped, and so is a touch that has not moved.
		if (r.touching == contact_down[s]) begin
			if (!r.touching) begin
				return 1'b0;
			end
			if (x == contact_x[s] && y == contact_y[s]) begin
				return 1'b0;
			end
		end
		// A release still records where it happened, though it reports zeros.
		contact_down[s] = r.touching;
		contact_x[s]    = x;
		contact_y[s]    = y;
		ev.point_valid  = 1'b1;
		ev.slot         = s[SLOT_OUT_W-1:0];
		ev.pressed      = r.touching;
		if (r.touching) begin
			ev.screen_x = x;
			ev.screen_y = y;
		end
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic queue_report(input logic k, input logic [ID_W-1:0] id, input logic t,
			input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y);
		touch_req_t r;
		r.kind     = k;
		r.touch_id = id;
		r.touching = t;
		r.raw_x    = x;
		r.raw_y    = y;
		pending_reports.push_back(r);
		queued_total++;
	endtask

	// Register writes go through their own channel. The local copy follows
	// only once the block has actually taken the write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			CFG_SCREEN_WIDTH:  scr_width  = val[SCREEN_W-1:0];
			CFG_SCREEN_HEIGHT: scr_height = val[SCREEN_W-1:0];
			CFG_PANEL_WIDTH:   pan_width  = val;
			CFG_PANEL_HEIGHT:  pan_height = val;
			default: ;
		endcase
	endtask

	task automatic set_scaling(input int sw, input int sh, input int pw, input int ph);
		write_reg(CFG_SCREEN_WIDTH, CFG_DATA_W'(sw));
		write_reg(CFG_SCREEN_HEIGHT, CFG_DATA_W'(sh));
		write_reg(CFG_PANEL_WIDTH, CFG_DATA_W'(pw));
		write_reg(CFG_PANEL_HEIGHT, CFG_DATA_W'(ph));
	endtask

	// Waits until every queued request has been taken and every result has
	// come back, then lets a dropped report finish its trip through the
	// divider before anything else happens.
	task automatic wait_until_quiet();
		while (accepted_total != queued_total || expected_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_screen_size();
		case ($urandom_range(9))
			0: return 1;
			1: return 4096;
			2: return 8191;
			default: return $urandom_range(2, 4095);
		endcase
	endfunction

	function automatic int pick_panel_extent();
		case ($urandom_range(9))
			0: return 65535;
			1: return $urandom_range(1, 15);
			default: return $urandom_range(256, 4096);
		endcase
	endfunction

	// Raw positions mostly fall inside the panel, with a small overshoot so
	// that the clamp is hit now and then; a few span the whole 16 bits.
	function automatic logic [RAW_W-1:0] pick_raw(input int extent);
		int top;
		if (extent == 0 || $urandom_range(9) == 0) begin
			return RAW_W'($urandom_range(65535));
		end
		top = extent + extent / 8;
		if (top > 65535) begin
			top = 65535;
		end
		return RAW_W'($urandom_range(top, 0));
	endfunction

	// Most random reports are well-formed contacts on live slots, a good share
	// of them at the last position used so that unchanged touches get dropped.
	// The rest are frame ends with junk in the unused fields and bad ids.
	function automatic touch_req_t make_random_report();
		touch_req_t r;
		int         pick;
		r.kind     = KIND_POINT;
		r.touch_id = ID_W'($urandom_range(TRACK_SLOTS, 1));
		r.touching = ($urandom_range(99) < 75);
		r.raw_x    = pick_raw(int'(pan_width));
		r.raw_y    = pick_raw(int'(pan_height));
		pick = $urandom_range(99);
		if (pick < 8) begin
			r.kind     = KIND_FRAME_END;
			r.touch_id = ID_W'($urandom_range(63));
			r.touching = 1'($urandom_range(1));
		end else if (pick < 13) begin
			r.touch_id = $urandom_range(1) ? '0 : ID_W'($urandom_range(63, TRACK_SLOTS + 1));
		end else if (pick < 43) begin
			r.raw_x = last_raw_x[r.touch_id];
			r.raw_y = last_raw_y[r.touch_id];
		end else if (pick < 55) begin
			r.raw_x = RAW_W'($urandom);
			r.raw_y = RAW_W'($urandom);
		end
		if (r.kind == KIND_POINT) begin
			last_raw_x[r.touch_id] = r.raw_x;
			last_raw_y[r.touch_id] = r.raw_y;
		end
		return r;
	endfunction

	// Request driver. A new report is offered only when the previous one has
	// gone or none is up, so valid and payload hold steady until taken. The
	// expected result is worked out at the very edge the block takes it.
	always @(posedge clk) begin : report_driver
		touch_evt_t ev;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				accepted_total++;
				if (cur_req.kind == KIND_FRAME_END) begin
					frame_total++;
				end
				if (track_report(cur_req, ev)) begin
					expected_events.push_back(ev);
				end else begin
					filtered_total++;
				end
			end
			if (!in_valid || in_ready) begin
				// Between the 300th and 450th request the sender never pauses.
				if (pending_reports.size() != 0 &&
						((accepted_total >= 300 && accepted_total < 450) ||
						$urandom_range(99) >= IDLE_PERCENT)) begin
					cur_req = pending_reports.pop_front();
					in_valid <= 1'b1;
					kind     <= cur_req.kind;
					touch_id <= cur_req.touch_id;
					touching <= cur_req.touching;
					raw_x    <= cur_req.raw_x;
					raw_y    <= cur_req.raw_y;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Every result taken is held against the oldest one still
	// outstanding. Once 150 results have been seen the receiver shuts its door
	// for a long while, so that the output register fills and the block has
	// to push back on the sender.
	always @(posedge clk) begin : result_monitor
		touch_evt_t seen;
		touch_evt_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				seen = {point_valid, frame_sync, slot, pressed, screen_x, screen_y};
				results_checked++;
				if (expected_events.size() == 0) begin
					flag_mismatch($sformatf("result with nothing outstanding: %h", seen));
				end else begin
					want = expected_events.pop_front();
					if (seen.point_valid !== want.point_valid)
						flag_mismatch($sformatf("point_valid got %0d want %0d",
							seen.point_valid, want.point_valid));
					if (seen.frame_sync !== want.frame_sync)
						flag_mismatch($sformatf("frame_sync got %0d want %0d",
							seen.frame_sync, want.frame_sync));
					if (seen.slot !== want.slot)
						flag_mismatch($sformatf("slot got %0d want %0d", seen.slot, want.slot));
					if (seen.pressed !== want.pressed)
						flag_mismatch($sformatf("pressed got %0d want %0d",
							seen.pressed, want.pressed));
					if (seen.screen_x !== want.screen_x)
						flag_mismatch($sformatf("screen_x got %0d want %0d",
							seen.screen_x, want.screen_x));
					if (seen.screen_y !== want.screen_y)
						flag_mismatch($sformatf("screen_y got %0d want %0d",
							seen.screen_y, want.screen_y));
				end
			end
			if (!long_hold_done && results_checked >= 150) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				// Between the 200th and 330th result the receiver takes everything offered.
				out_ready <= (results_checked >= 200 && results_checked < 330) ||
					($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// Watchdog: a run in which nothing moves on any channel for too long has hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timed out: no request or result moved for %0d cycles", QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset scaling: both panel extents are zero, so every coordinate is zero.
		// A frame end with every unused field at its top value, then the three
		// kinds of bad id, then a touch that cannot move, and a double release.
		queue_report(KIND_FRAME_END, 6'd63, 1'b1, 16'hFFFF, 16'hFFFF);
		queue_report(KIND_POINT, 6'd0, 1'b1, 16'd100, 16'd100);
		queue_report(KIND_POINT, 6'd11, 1'b1, 16'd100, 16'd100);
		queue_report(KIND_POINT, 6'd63, 1'b1, 16'd100, 16'd100);
		queue_report(KIND_POINT, 6'd1, 1'b1, 16'hFFFF, 16'hFFFF);
		queue_report(KIND_POINT, 6'd1, 1'b1, 16'd1234, 16'd777);
		queue_report(KIND_POINT, 6'd1, 1'b0, 16'd5, 16'd5);
		queue_report(KIND_POINT, 6'd1, 1'b0, 16'd5, 16'd5);
		queue_report(KIND_POINT, 6'd10, 1'b1, 16'd0, 16'd0);
		wait_until_quiet();

		// A common panel: raw beyond the extent clamps to the screen edge, and
		// two raw positions that scale to the same point count as no movement.
		set_scaling(800, 480, 4096, 4096);
		queue_report(KIND_POINT, 6'd2, 1'b1, 16'd0, 16'd0);
		queue_report(KIND_POINT, 6'd2, 1'b1, 16'hFFFF, 16'hFFFF);
		queue_report(KIND_POINT, 6'd2, 1'b1, 16'hFFFF, 16'hFFFF);
		queue_report(KIND_POINT, 6'd2, 1'b1, 16'd4096, 16'd4096);
		queue_report(KIND_POINT, 6'd2, 1'b1, 16'd2048, 16'd1024);
		queue_report(KIND_POINT, 6'd2, 1'b0, 16'd100, 16'd100);
		queue_report(KIND_POINT, 6'd10, 1'b0, 16'd0, 16'd0);
		queue_report(KIND_FRAME_END, 6'd0, 1'b0, 16'd0, 16'd0);
		wait_until_quiet();

		// A zero screen width, and a screen height beyond the 12-bit field.
		set_scaling(0, 8191, 65535, 1);
		queue_report(KIND_POINT, 6'd3, 1'b1, 16'hFFFF, 16'hFFFF);
		queue_report(KIND_POINT, 6'd3, 1'b1, 16'd0, 16'd0);
		queue_report(KIND_POINT, 6'd4, 1'b1, 16'd5555, 16'd0);
		wait_until_quiet();

		// One-pixel-wide screen and the largest panel height.
		set_scaling(1, 4096, 1, 65535);
		queue_report(KIND_POINT, 6'd5, 1'b1, 16'hFFFF, 16'hFFFF);
		queue_report(KIND_POINT, 6'd5, 1'b1, 16'd1, 16'd32768);
		queue_report(KIND_FRAME_END, 6'd42, 1'b1, 16'h5555, 16'hAAAA);
		wait_until_quiet();

		// Random phases, each with its own scaling picked while the block is idle.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_scaling(pick_screen_size(), pick_screen_size(),
				pick_panel_extent(), pick_panel_extent());
			for (int n = 0; n < REPORTS_PER_PHASE; n++) begin
				pending_reports.push_back(make_random_report());
				queued_total++;
			end
			wait_until_quiet();
		end

		$display("Sent %0d touch reports (%0d frame ends, %0d silently filtered) under %0d",
			accepted_total, frame_total, filtered_total, reg_writes);
		$display("register writes; %0d results compared, %0d mismatches.",
			results_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[files.f]
sv/trsf_pkg.sv
sv/touch_report_scale_filter.sv
tb/touch_report_scale_filter_tb.sv
